/* design/e2q_pkg.sv */
// e2q_pkg: shared constants and types for the euler to quaternion pipeline
// depends on nothing
package e2q_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int QUAT_BITS_DEF  = 16;
   localparam int WORK_FRAC      = 24;
   localparam int CORDIC_STEPS   = 20;
   localparam int TRIG_W         = 28;   // q.24 sine / cosine with headroom
   localparam int COMP_W         = 28;   // q.24 component
   localparam int N2_W           = 52;   // q.48 sum of squares
   localparam int NORM_W         = 26;

   localparam logic signed [TRIG_W-1:0] GAIN_INIT = 28'sd10188014;
   localparam logic signed [TRIG_W-1:0] HALF_PI_W = 28'sd26353589;
   localparam logic signed [TRIG_W-1:0] PI_W      = 28'sd52707179;

   function automatic logic signed [TRIG_W-1:0] atan_val(input int i);
      logic signed [TRIG_W-1:0] a;
      begin
         case (i)
            0: a = 28'sd13176795;
            1: a = 28'sd7778716;
            2: a = 28'sd4110060;
            3: a = 28'sd2086331;
            4: a = 28'sd1047214;
            5: a = 28'sd524117;
            6: a = 28'sd262123;
            7: a = 28'sd131069;
            default: a = TRIG_W'(28'sd1 <<< (WORK_FRAC - i));
         endcase
         return a;
      end
   endfunction

   typedef struct packed {
      logic signed [TRIG_W-1:0] x;
      logic signed [TRIG_W-1:0] y;
      logic signed [TRIG_W-1:0] z;
      logic                     flip;
   } cordic_type;

endpackage

/* design/euler_to_quaternion_core.sv */
// euler_to_quaternion_core: top level, angle triple in, unit quaternion out
// depends on e2q_pkg, e2q_cordic, e2q_combine, e2q_normalize
// A fully pipelined converter: a transaction can start in every cycle (busy is
// always low) and its result appears on the rsp_ ports, marked by rsp_valid for
// one cycle. A transaction passes through the cordic (input register and 20
// steps), the products, the sum of squares, the one-bit-per-stage square root,
// the one-bit-per-stage divider and one output register. The receiver cannot
// stall, so nothing backs up.
module euler_to_quaternion_core #(
   parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF,
   parameter int QUAT_BITS  = e2q_pkg::QUAT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [ANGLE_BITS-1:0] req_roll_angle,
   input  logic signed [ANGLE_BITS-1:0] req_pitch_angle,
   input  logic signed [ANGLE_BITS-1:0] req_yaw_angle,
   output logic                         rsp_valid,
   output logic signed [QUAT_BITS-1:0]  rsp_quat_x,
   output logic signed [QUAT_BITS-1:0]  rsp_quat_y,
   output logic signed [QUAT_BITS-1:0]  rsp_quat_z,
   output logic signed [QUAT_BITS-1:0]  rsp_quat_w
);
   localparam int TW = e2q_pkg::TRIG_W;
   localparam int CW = e2q_pkg::COMP_W;
   localparam int LATENCY = (e2q_pkg::CORDIC_STEPS + 1) + 3 + 2
                          + e2q_pkg::NORM_W + (CW + QUAT_BITS - 1) + 1;

   logic signed [TW-1:0] sr, cr, sp, cp, sy, cy;
   logic signed [CW-1:0] qx, qy, qz, qw;
   logic [LATENCY-1:0] valid_ff, valid_in;

   assign busy = 1'b0;

   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
      .clock(clock), .angle(req_roll_angle), .sin_out(sr), .cos_out(cr));
   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
      .clock(clock), .angle(req_pitch_angle), .sin_out(sp), .cos_out(cp));
   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
      .clock(clock), .angle(req_yaw_angle), .sin_out(sy), .cos_out(cy));

   e2q_combine u_comb (
      .clock(clock), .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
      .qx(qx), .qy(qy), .qz(qz), .qw(qw));

   e2q_normalize #(.QUAT_BITS(QUAT_BITS)) u_norm (
      .clock(clock), .qx(qx), .qy(qy), .qz(qz), .qw(qw),
      .ox(rsp_quat_x), .oy(rsp_quat_y), .oz(rsp_quat_z), .ow(rsp_quat_w));

   assign valid_in = {valid_ff[LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   assign rsp_valid = valid_ff[LATENCY-1];

   // every transaction that starts yields a result at the end of the valid pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> ##(LATENCY-1) rsp_valid) else $error("lost result");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(valid_ff[LATENCY-2])) else $error("spurious result");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_quat_w) <= $signed(QUAT_BITS'(1) << (QUAT_BITS-2))))
      else $error("w out of range");
endmodule

/* design/e2q_cordic.sv */
// e2q_cordic: pipelined half-angle sine / cosine, one cordic step per stage
// depends on e2q_pkg
module e2q_cordic #(
   parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
   input  logic                                    clock,
   input  logic signed [ANGLE_BITS-1:0]            angle,
   output logic signed [e2q_pkg::TRIG_W-1:0]       sin_out,
   output logic signed [e2q_pkg::TRIG_W-1:0]       cos_out
);
   localparam int TW = e2q_pkg::TRIG_W;
   localparam int NS = e2q_pkg::CORDIC_STEPS;
   localparam int HF = ANGLE_BITS - 2;

   e2q_pkg::cordic_type stage_ff [NS+1];
   e2q_pkg::cordic_type stage_in [NS+1];
   logic signed [TW-1:0] th;

   always_comb begin
      if (HF <= e2q_pkg::WORK_FRAC)
         th = TW'(angle) <<< (HF <= e2q_pkg::WORK_FRAC ? e2q_pkg::WORK_FRAC - HF : 0);
      else
         th = TW'(angle >>> (HF > e2q_pkg::WORK_FRAC ? HF - e2q_pkg::WORK_FRAC : 0));
      stage_in[0].x    = e2q_pkg::GAIN_INIT;
      stage_in[0].y    = '0;
      stage_in[0].flip = 1'b0;
      stage_in[0].z    = th;
      if (th > e2q_pkg::HALF_PI_W) begin
         stage_in[0].z = th - e2q_pkg::PI_W;
         stage_in[0].flip = 1'b1;
      end else if (th < -e2q_pkg::HALF_PI_W) begin
         stage_in[0].z = th + e2q_pkg::PI_W;
         stage_in[0].flip = 1'b1;
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_step
      always_comb begin
         stage_in[i+1].flip = stage_ff[i].flip;
         if (!stage_ff[i].z[TW-1]) begin
            stage_in[i+1].x = stage_ff[i].x - (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y + (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z - e2q_pkg::atan_val(i);
         end else begin
            stage_in[i+1].x = stage_ff[i].x + (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y - (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z + e2q_pkg::atan_val(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NS; k++) stage_ff[k] <= stage_in[k];
   end

   assign cos_out = stage_ff[NS].flip ? -stage_ff[NS].x : stage_ff[NS].x;
   assign sin_out = stage_ff[NS].flip ? -stage_ff[NS].y : stage_ff[NS].y;
endmodule

/* design/e2q_combine.sv */
// e2q_combine: products of half-angle sines and cosines into raw components
// depends on e2q_pkg; two multiply stages, each registered
module e2q_combine (
   input  logic                                 clock,
   input  logic signed [e2q_pkg::TRIG_W-1:0]    sr, cr, sp, cp, sy, cy,
   output logic signed [e2q_pkg::COMP_W-1:0]    qx, qy, qz, qw
);
   localparam int TW = e2q_pkg::TRIG_W;
   localparam int WF = e2q_pkg::WORK_FRAC;

   logic signed [TW-1:0] cpcy_ff, spcy_ff, cpsy_ff, spsy_ff, sr_ff, cr_ff;
   logic signed [2*TW-1:0] p_ff [8];
   logic signed [2*TW-1:0] p_in [8];
   logic signed [2*TW:0] sx, sy_, sz, sw;

   always_ff @(posedge clock) begin
      cpcy_ff <= TW'(((2*TW)'(cp) * (2*TW)'(cy)) >>> WF);
      spcy_ff <= TW'(((2*TW)'(sp) * (2*TW)'(cy)) >>> WF);
      cpsy_ff <= TW'(((2*TW)'(cp) * (2*TW)'(sy)) >>> WF);
      spsy_ff <= TW'(((2*TW)'(sp) * (2*TW)'(sy)) >>> WF);
      sr_ff   <= sr;
      cr_ff   <= cr;
   end

   always_comb begin
      p_in[0] = sr_ff * cpcy_ff;  p_in[1] = cr_ff * spsy_ff;
      p_in[2] = cr_ff * spcy_ff;  p_in[3] = sr_ff * cpsy_ff;
      p_in[4] = cr_ff * cpsy_ff;  p_in[5] = sr_ff * spcy_ff;
      p_in[6] = cr_ff * cpcy_ff;  p_in[7] = sr_ff * spsy_ff;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 8; k++) p_ff[k] <= p_in[k];
   end

   always_comb begin
      sx  = (2*TW+1)'(p_ff[0]) - (2*TW+1)'(p_ff[1]);
      sy_ = (2*TW+1)'(p_ff[2]) + (2*TW+1)'(p_ff[3]);
      sz  = (2*TW+1)'(p_ff[4]) - (2*TW+1)'(p_ff[5]);
      sw  = (2*TW+1)'(p_ff[6]) + (2*TW+1)'(p_ff[7]);
   end

   always_ff @(posedge clock) begin
      qx <= e2q_pkg::COMP_W'(sx >>> WF);
      qy <= e2q_pkg::COMP_W'(sy_ >>> WF);
      qz <= e2q_pkg::COMP_W'(sz >>> WF);
      qw <= e2q_pkg::COMP_W'(sw >>> WF);
   end
endmodule

/* design/e2q_normalize.sv */
// e2q_normalize: pipelined sum of squares, integer square root and division
// depends on e2q_pkg; one root bit and one quotient bit per stage
module e2q_normalize #(
   parameter int QUAT_BITS = e2q_pkg::QUAT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic signed [e2q_pkg::COMP_W-1:0]    qx, qy, qz, qw,
   output logic signed [QUAT_BITS-1:0]          ox, oy, oz, ow
);
   localparam int CW = e2q_pkg::COMP_W;
   localparam int NW = e2q_pkg::N2_W;
   localparam int RW = e2q_pkg::NORM_W;
   localparam int QF = QUAT_BITS - 2;
   localparam int MW = CW + QF + 1;        // dividend width
   localparam int QW = MW;                 // quotient bits

   // stage: squares
   logic [NW-1:0] sq_ff [4];
   logic signed [CW-1:0] q0_ff [4];
   always_ff @(posedge clock) begin
      sq_ff[0] <= NW'(NW'(qx) * NW'(qx)); sq_ff[1] <= NW'(NW'(qy) * NW'(qy));
      sq_ff[2] <= NW'(NW'(qz) * NW'(qz)); sq_ff[3] <= NW'(NW'(qw) * NW'(qw));
      q0_ff[0] <= qx; q0_ff[1] <= qy; q0_ff[2] <= qz; q0_ff[3] <= qw;
   end

   logic [NW-1:0] n2_ff;
   logic signed [CW-1:0] q1_ff [4];
   always_ff @(posedge clock) begin
      n2_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2] + sq_ff[3];
      q1_ff <= q0_ff;
   end

   // square root: restoring, one result bit per stage
   logic [NW-1:0] rem_ff [RW+1];
   logic [RW-1:0] root_ff [RW+1];
   logic signed [CW-1:0] qs_ff [RW+1][4];
   always_comb begin
      rem_ff[0]  = n2_ff;
      root_ff[0] = '0;
      qs_ff[0]   = q1_ff;
   end
   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      localparam int B = RW - 1 - i;
      logic [NW+1:0] trial;
      assign trial = ((NW+2)'(root_ff[i]) << (B + 1)) + ((NW+2)'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (trial <= (NW+2)'(rem_ff[i])) begin
            rem_ff[i+1]  <= NW'((NW+2)'(rem_ff[i]) - trial);
            root_ff[i+1] <= root_ff[i] | (RW'(1) << B);
         end else begin
            rem_ff[i+1]  <= rem_ff[i];
            root_ff[i+1] <= root_ff[i];
         end
         qs_ff[i+1] <= qs_ff[i];
      end
   end

   // division: per lane, restoring, rounded by adding half the norm
   logic [RW-1:0] norm;
   assign norm = root_ff[RW];
   logic [RW-1:0] nrm_ff [QW+1];
   assign nrm_ff[0] = norm;
   for (genvar i = 0; i < QW; i++) begin : g_nd
      always_ff @(posedge clock) nrm_ff[i+1] <= nrm_ff[i];
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [MW-1:0] num_ff [QW+1];
      logic [RW:0]   rm_ff  [QW+1];
      logic [QW-1:0] quo_ff [QW+1];
      logic          neg_ff [QW+1];
      logic [CW-1:0] mag;
      assign mag = qs_ff[RW][l][CW-1] ? CW'(-qs_ff[RW][l]) : CW'(qs_ff[RW][l]);
      assign num_ff[0] = (MW'(mag) << QF) + MW'(norm >> 1);
      assign rm_ff[0]  = '0;
      assign quo_ff[0] = '0;
      assign neg_ff[0] = qs_ff[RW][l][CW-1];
      for (genvar i = 0; i < QW; i++) begin : g_div
         logic [RW+1:0] t;
         assign t = {rm_ff[i], num_ff[i][MW-1-i]};
         always_ff @(posedge clock) begin
            if (t >= (RW+2)'(nrm_ff[i])) begin
               rm_ff[i+1]  <= (RW+1)'(t - (RW+2)'(nrm_ff[i]));
               quo_ff[i+1] <= quo_ff[i] | (QW'(1) << (QW - 1 - i));
            end else begin
               rm_ff[i+1]  <= (RW+1)'(t);
               quo_ff[i+1] <= quo_ff[i];
            end
            num_ff[i+1] <= num_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
      end
      logic [QW-1:0] sat;
      logic [QUAT_BITS-1:0] res;
      always_comb begin
         sat = (quo_ff[QW] > (QW'(1) << QF)) ? (QW'(1) << QF) : quo_ff[QW];
         res = neg_ff[QW] ? QUAT_BITS'(-sat) : QUAT_BITS'(sat);
         if (nrm_ff[QW] == '0) res = (l == 3) ? (QUAT_BITS'(1) << QF) : '0;
      end
      logic [QUAT_BITS-1:0] res_ff;
      always_ff @(posedge clock) res_ff <= res;
      if (l == 0) begin : g_o0 assign ox = res_ff; end
      if (l == 1) begin : g_o1 assign oy = res_ff; end
      if (l == 2) begin : g_o2 assign oz = res_ff; end
      if (l == 3) begin : g_o3 assign ow = res_ff; end
   end
endmodule

/* dv/euler_to_quaternion_checker.sv */
// euler_to_quaternion_checker: watches the angle and quaternion ports, predicts
// each quaternion (q.24 working values, q.14 result) and compares; depends on nothing else
`timescale 1ns / 100ps
module euler_to_quaternion_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_yaw_angle,
   input  logic               rsp_valid,
   input  logic signed [15:0] rsp_quat_x,
   input  logic signed [15:0] rsp_quat_y,
   input  logic signed [15:0] rsp_quat_z,
   input  logic signed [15:0] rsp_quat_w,
   output int                 errors,
   output int                 pending
);

   localparam longint GAIN  = 10188014;
   localparam longint HPI   = 26353589;
   localparam longint PI_Q  = 52707179;
   localparam int     QFRAC = 14;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic signed [15:0] w;
   } quat_t;

   quat_t quat_q[$];

   function automatic longint atan_step(int i);
      case (i)
         0: return 13176795;
         1: return 7778716;
         2: return 4110060;
         3: return 2086331;
         4: return 1047214;
         5: return 524117;
         6: return 262123;
         7: return 131069;
         default: return longint'(1) << (24 - i);
      endcase
   endfunction

   // sine and cosine of half the angle, q.24, with cordic gain baked in
   task automatic half_trig(input logic signed [15:0] ang, output longint s,
                            output longint c);
      longint th, x, y, z, dx, dy, a;
      bit flip;
      th = longint'(ang) <<< 10;
      flip = 0;
      if (th > HPI) begin
         th -= PI_Q;
         flip = 1;
      end else if (th < -HPI) begin
         th += PI_Q;
         flip = 1;
      end
      x = GAIN;
      y = 0;
      z = th;
      for (int i = 0; i < 20; i++) begin
         a = atan_step(i);
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= a;
         end else begin
            x += dx; y -= dy; z += a;
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] scale_q14(longint q, logic [63:0] norm);
      logic [63:0] mag, r;
      mag = (q < 0) ? -q : q;
      r = ((mag << QFRAC) + (norm >> 1)) / norm;
      if (r > (64'd1 << QFRAC)) r = 64'd1 << QFRAC;
      if (q < 0) r = -r;
      return r[15:0];
   endfunction

   task automatic predict_quat(input logic signed [15:0] roll, pitch, yaw);
      longint sr, cr, sp, cp, sy, cy, cpcy, spcy, cpsy, spsy, qx, qy, qz, qw;
      logic [63:0] n2, norm;
      quat_t e;
      half_trig(roll, sr, cr);
      half_trig(pitch, sp, cp);
      half_trig(yaw, sy, cy);
      cpcy = (cp * cy) >>> 24;
      spcy = (sp * cy) >>> 24;
      cpsy = (cp * sy) >>> 24;
      spsy = (sp * sy) >>> 24;
      qx = (sr * cpcy - cr * spsy) >>> 24;
      qy = (cr * spcy + sr * cpsy) >>> 24;
      qz = (cr * cpsy - sr * spcy) >>> 24;
      qw = (cr * cpcy + sr * spsy) >>> 24;
      n2 = qx * qx + qy * qy + qz * qz + qw * qw;
      norm = int_sqrt(n2);
      if (norm == 0) begin
         e = '{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: 16'sd16384};
      end else begin
         e.x = scale_q14(qx, norm);
         e.y = scale_q14(qy, norm);
         e.z = scale_q14(qz, norm);
         e.w = scale_q14(qw, norm);
      end
      quat_q.push_back(e);
   endtask

   task automatic check_field(string name, logic signed [15:0] exp_v, act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   initial begin
      errors = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      quat_t e;
      if (!reset) begin
         if (start && !busy)
            predict_quat(req_roll_angle, req_pitch_angle, req_yaw_angle);
         if (rsp_valid) begin
            if (quat_q.size() == 0) begin
               $error("quaternion with no transaction outstanding");
               errors++;
            end else begin
               e = quat_q.pop_front();
               check_field("quat_x", e.x, rsp_quat_x);
               check_field("quat_y", e.y, rsp_quat_y);
               check_field("quat_z", e.z, rsp_quat_z);
               check_field("quat_w", e.w, rsp_quat_w);
            end
         end
      end
      pending = quat_q.size();
   end

endmodule

/* dv/euler_to_quaternion_core_tb.sv */
// euler_to_quaternion_core_tb: drives angle triples into euler_to_quaternion_core
// depends on euler_to_quaternion_core and euler_to_quaternion_checker
`timescale 1ns / 100ps
module euler_to_quaternion_core_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN       = 200;

   logic               clock, reset, start, busy, rsp_valid;
   logic signed [15:0] req_roll_angle, req_pitch_angle, req_yaw_angle;
   logic signed [15:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   int                 errors, pending, cycles;

   euler_to_quaternion_core i_dut (.*);
   euler_to_quaternion_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("euler_to_quaternion_core verification failed");
            $finish;
         end
      end
   end

   // one transaction, with a random gap before it unless gaps are off
   task automatic send_angles(input logic signed [15:0] r, p, y, input bit gaps);
      if (gaps) begin
         while ($urandom_range(99) < 30) begin
            start <= 0;
            @(negedge clock);
         end
      end
      start <= 1;
      req_roll_angle <= r;
      req_pitch_angle <= p;
      req_yaw_angle <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_angle();
      case ($urandom_range(9))
         0: return 16'($urandom);
         1: return 16'(25736 - $urandom_range(40));
         2: return 16'(-25736 + $urandom_range(40));
         default: return 16'($signed($urandom_range(51472)) - 25736);
      endcase
   endfunction

   initial begin
      logic signed [15:0] corner [10];
      corner = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd32767, -16'sd32768,
                 16'sd12868, -16'sd12868, 16'sd12869, -16'sd12869, 16'sd1};
      reset = 1;
      start = 0;
      req_roll_angle = 0;
      req_pitch_angle = 0;
      req_yaw_angle = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // field extremes, pi boundaries (where the half angle folds) and angles at half pi
      for (int i = 0; i < 10; i++)
         send_angles(corner[i], corner[(i + 3) % 10], corner[(i + 7) % 10], 1);
      send_angles(16'sd32767, 16'sd32767, 16'sd32767, 1);
      send_angles(-16'sd32768, -16'sd32768, -16'sd32768, 1);
      for (int i = 0; i < 1500; i++)
         send_angles(rand_angle(), rand_angle(), rand_angle(), !(i >= 500 && i < 800));
      start <= 0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0)
         $display("euler_to_quaternion_core verification clean");
      else
         $display("euler_to_quaternion_core verification failed");
      $finish;
   end

endmodule
